// ----- sv/idq_pkg.sv -----
package idq_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 4;
  localparam int FUNC_W   = 3;
  localparam int STAT_W   = 2;

  localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_BACK   = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_READ       = 3'd4,
    FN_WRITE      = 3'd5
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic                     we;
    logic                     re;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] wdata;
  } mem_req_t;

endpackage

// ----- sv/idq_ram.sv -----
module idq_ram (
  input  logic                              clk,
  input  idq_pkg::mem_req_t                 req,
  output logic signed [idq_pkg::DATA_W-1:0] rd_data
);

  logic signed [idq_pkg::DATA_W-1:0] mem [idq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

// ----- sv/idq_ctrl.sv -----
module idq_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [idq_pkg::FUNC_W-1:0]        func,
  input  logic signed [idq_pkg::DATA_W-1:0] value,
  input  logic [idq_pkg::POS_W-1:0]         position,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic signed [idq_pkg::DATA_W-1:0] data,
  output logic [idq_pkg::CNT_W-1:0]         count,
  output logic [idq_pkg::STAT_W-1:0]        status,
  output idq_pkg::mem_req_t                 mem_req,
  input  logic signed [idq_pkg::DATA_W-1:0] rd_data
);

  typedef enum logic [1:0] {IDLE, RD, HOLD} state_t;

  state_t                            state;
  logic [idq_pkg::ADDR_W-1:0]        head;
  logic [idq_pkg::ADDR_W-1:0]        head_next;
  logic [idq_pkg::CNT_W-1:0]         used;
  logic [idq_pkg::CNT_W-1:0]         used_next;
  idq_pkg::status_t                  stat_next;
  logic                              need_rd;
  logic                              accept;
  logic                              out_free;
  logic                              out_load;
  logic signed [idq_pkg::DATA_W-1:0] pend_data;
  logic [idq_pkg::CNT_W-1:0]         pend_count;
  logic [idq_pkg::STAT_W-1:0]        pend_status;
  logic                              full;
  logic                              empty;
  logic                              out_of_range;
  logic [idq_pkg::ADDR_W-1:0]        used_lo;

  assign s_tready     = (state == IDLE);
  assign accept       = s_tvalid && s_tready;
  assign out_free     = !m_tvalid || m_tready;
  assign out_load     = out_free && (((state == IDLE) && accept && !need_rd) ||
                                     (state == RD) || (state == HOLD));
  assign full         = (used == idq_pkg::FULL_COUNT);
  assign empty        = (used == '0);
  assign out_of_range = (idq_pkg::CNT_W'(position) >= used);
  assign used_lo      = used[idq_pkg::ADDR_W-1:0];

  // decode one request against head and count
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = value;
    head_next     = head;
    used_next     = used;
    stat_next     = idq_pkg::ST_OK;
    need_rd       = 1'b0;
    unique case (func)
      idq_pkg::FN_PUSH_BACK: begin
        if (full) begin
          stat_next = idq_pkg::ST_FULL;
        end else begin
          mem_req.we   = accept;
          mem_req.addr = head + used_lo;
          used_next    = used + 1'b1;
        end
      end
      idq_pkg::FN_PUSH_FRONT: begin
        if (full) begin
          stat_next = idq_pkg::ST_FULL;
        end else begin
          mem_req.we   = accept;
          mem_req.addr = head - 1'b1;
          head_next    = head - 1'b1;
          used_next    = used + 1'b1;
        end
      end
      idq_pkg::FN_POP_BACK: begin
        if (empty) begin
          stat_next = idq_pkg::ST_EMPTY;
        end else begin
          mem_req.re   = accept;
          mem_req.addr = head + used_lo - 1'b1;
          used_next    = used - 1'b1;
          need_rd      = 1'b1;
        end
      end
      idq_pkg::FN_POP_FRONT: begin
        if (empty) begin
          stat_next = idq_pkg::ST_EMPTY;
        end else begin
          mem_req.re   = accept;
          mem_req.addr = head;
          head_next    = head + 1'b1;
          used_next    = used - 1'b1;
          need_rd      = 1'b1;
        end
      end
      idq_pkg::FN_READ: begin
        if (out_of_range) begin
          stat_next = idq_pkg::ST_RANGE;
        end else begin
          mem_req.re   = accept;
          mem_req.addr = head + position[idq_pkg::ADDR_W-1:0];
          need_rd      = 1'b1;
        end
      end
      idq_pkg::FN_WRITE: begin
        if (out_of_range) begin
          stat_next = idq_pkg::ST_RANGE;
        end else begin
          mem_req.we   = accept;
          mem_req.addr = head + position[idq_pkg::ADDR_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      head     <= '0;
      used     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            head        <= head_next;
            used        <= used_next;
            pend_count  <= used_next;
            pend_status <= stat_next;
            pend_data   <= '0;
            if (need_rd) begin
              state <= RD;
            end else if (out_free) begin
              data     <= '0;
              count    <= used_next;
              status   <= stat_next;
            end else begin
              state <= HOLD;
            end
          end
        end
        RD: begin
          pend_data <= rd_data;
          if (out_free) begin
            data     <= rd_data;
            count    <= pend_count;
            status   <= pend_status;
            state    <= IDLE;
          end else begin
            state <= HOLD;
          end
        end
        HOLD: begin
          if (out_free) begin
            data     <= pend_data;
            count    <= pend_count;
            status   <= pend_status;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/indexed_double_ended_queue_top.sv -----
// indexed double-ended queue of 16 signed 32-bit elements
// input channel s_*: one request per transfer
//   s_tuser carries the operation: push back, push front, pop back, pop front,
//   read at index, write at index
//   s_tdata carries the element and the index counted from the front
// output channel m_*: exactly one result per request, in request order
//   m_tdata carries the element read or removed (zero otherwise) and the count
//   after the operation; m_tuser carries the status
//   (ok, full push dropped, empty pop, index out of range)
// pushes, writes and errors load the result register directly; pops and
//   reads first pass through the registered read of the element ram
// throughput: one request per cycle for pushes, writes and errors while the
//   result register is free; the control accepts a new request only once
//   the previous one has left for the result register
// reset: rst (synchronous) empties the queue and drops any pending result;
//   the ram contents are not cleared
// when m_tready is low the result holds, one more result waits in a hold
//   stage, and s_tready then stays low until the result register frees up
module indexed_double_ended_queue_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [idq_pkg::S_TDATA_W-1:0]     s_tdata,  // value, position, zero pad
  input  logic [idq_pkg::FUNC_W-1:0]        s_tuser,  // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [idq_pkg::M_TDATA_W-1:0]     m_tdata,  // data, count, zero pad
  output logic [idq_pkg::STAT_W-1:0]        m_tuser   // status
);

  idq_pkg::mem_req_t                 mem_req;
  logic signed [idq_pkg::DATA_W-1:0] rd_data;
  logic signed [idq_pkg::DATA_W-1:0] value;
  logic [idq_pkg::POS_W-1:0]         position;
  logic signed [idq_pkg::DATA_W-1:0] data;
  logic [idq_pkg::CNT_W-1:0]         count;

  assign value    = s_tdata[idq_pkg::DATA_W-1:0];
  assign position = s_tdata[idq_pkg::DATA_W +: idq_pkg::POS_W];
  assign m_tdata  = idq_pkg::M_TDATA_W'({count, data});

  idq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .func     (s_tuser),
    .value    (value),
    .position (position),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .data     (data),
    .count    (count),
    .status   (m_tuser),
    .mem_req  (mem_req),
    .rd_data  (rd_data)
  );

  idq_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule

// ----- bench/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [idq_pkg::FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [idq_pkg::FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam int NUM_DIRECTED = 23;
  localparam int NUM_RANDOM   = 1250;
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_AT_REQ  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic signed [idq_pkg::DATA_W-1:0] data;
    logic [idq_pkg::CNT_W-1:0]         count;
    idq_pkg::status_t                  status;
  } result_t;

  typedef struct packed {
    logic [idq_pkg::FUNC_W-1:0] fn;
    logic [idq_pkg::DATA_W-1:0] value;
    logic [idq_pkg::POS_W-1:0]  pos;
    logic [4:0]                 reps;
    logic                       fixed_exp;
    logic [idq_pkg::DATA_W-1:0] exp_data;
    logic [idq_pkg::CNT_W-1:0]  exp_count;
    logic [idq_pkg::STAT_W-1:0] exp_status;
  } stim_row_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [idq_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic [idq_pkg::FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [idq_pkg::M_TDATA_W-1:0] m_tdata;
  logic [idq_pkg::STAT_W-1:0] m_tuser;

  indexed_double_ended_queue_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // shadow copy of the queue
  logic signed [idq_pkg::DATA_W-1:0] shadow_store [idq_pkg::CAPACITY];
  logic [idq_pkg::ADDR_W-1:0]        shadow_head = '0;
  logic [idq_pkg::CNT_W-1:0]         shadow_count = '0;

  result_t expected_results [$];
  stim_row_t directed_rows [NUM_DIRECTED];

  int n_sent = 0;
  int burst_left = 0;
  int mismatch_count = 0;
  int result_index = 0;
  int cycle_count = 0;

  function automatic int phys_slot(int k);
    return (int'(shadow_head) + k) % idq_pkg::CAPACITY;
  endfunction

  function automatic result_t apply_op(logic [idq_pkg::FUNC_W-1:0] fn,
                                       logic signed [idq_pkg::DATA_W-1:0] val,
                                       logic [idq_pkg::POS_W-1:0] pos);
    result_t r;
    r.data = '0;
    r.status = idq_pkg::ST_OK;
    case (fn)
      idq_pkg::FN_PUSH_BACK: begin
        if (shadow_count >= idq_pkg::FULL_COUNT) r.status = idq_pkg::ST_FULL;
        else begin
          shadow_store[phys_slot(int'(shadow_count))] = val;
          shadow_count = shadow_count + 1'b1;
        end
      end
      idq_pkg::FN_PUSH_FRONT: begin
        if (shadow_count >= idq_pkg::FULL_COUNT) r.status = idq_pkg::ST_FULL;
        else begin
          shadow_head = idq_pkg::ADDR_W'((int'(shadow_head) + idq_pkg::CAPACITY - 1) %
                                         idq_pkg::CAPACITY);
          shadow_store[shadow_head] = val;
          shadow_count = shadow_count + 1'b1;
        end
      end
      idq_pkg::FN_POP_BACK: begin
        if (shadow_count == '0) r.status = idq_pkg::ST_EMPTY;
        else begin
          shadow_count = shadow_count - 1'b1;
          r.data = shadow_store[phys_slot(int'(shadow_count))];
        end
      end
      idq_pkg::FN_POP_FRONT: begin
        if (shadow_count == '0) r.status = idq_pkg::ST_EMPTY;
        else begin
          r.data = shadow_store[shadow_head];
          shadow_head = idq_pkg::ADDR_W'((int'(shadow_head) + 1) % idq_pkg::CAPACITY);
          shadow_count = shadow_count - 1'b1;
        end
      end
      idq_pkg::FN_READ: begin
        if (idq_pkg::CNT_W'(pos) >= shadow_count) r.status = idq_pkg::ST_RANGE;
        else r.data = shadow_store[phys_slot(int'(pos))];
      end
      idq_pkg::FN_WRITE: begin
        if (idq_pkg::CNT_W'(pos) >= shadow_count) r.status = idq_pkg::ST_RANGE;
        else shadow_store[phys_slot(int'(pos))] = val;
      end
      default: ;
    endcase
    r.count = shadow_count;
    return r;
  endfunction

  function automatic logic [idq_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return idq_pkg::DATA_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string field,
                                 input logic [idq_pkg::M_TDATA_W-1:0] got,
                                 input logic [idq_pkg::M_TDATA_W-1:0] want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch on %s at result %0d: got %h, expected %h",
               field, result_index, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [idq_pkg::FUNC_W-1:0] fn,
                              input logic [idq_pkg::DATA_W-1:0] val,
                              input logic [idq_pkg::POS_W-1:0] pos, input logic use_fixed,
                              input result_t fixed_res);
    result_t predicted;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= idq_pkg::S_TDATA_W'({pos, val});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_op(fn, val, pos);
    expected_results.insert(expected_results.size(), use_fixed ? fixed_res : predicted);
    burst_left--;
    n_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (m_tdata[idq_pkg::DATA_W-1:0] !== want.data)
          report_mismatch("data", idq_pkg::M_TDATA_W'(m_tdata[idq_pkg::DATA_W-1:0]),
                          idq_pkg::M_TDATA_W'(want.data));
        if (m_tdata[idq_pkg::DATA_W +: idq_pkg::CNT_W] !== want.count)
          report_mismatch("count",
                          idq_pkg::M_TDATA_W'(m_tdata[idq_pkg::DATA_W +: idq_pkg::CNT_W]),
                          idq_pkg::M_TDATA_W'(want.count));
        if (m_tuser !== want.status)
          report_mismatch("status", idq_pkg::M_TDATA_W'(m_tuser),
                          idq_pkg::M_TDATA_W'(want.status));
      end
      result_index++;
    end
  end

  // receiver stalls, with one long hold-off so the block backs up
  initial begin : receiver
    int phase_left;
    rx_mode_t mode;
    logic [7:0] pat;
    bit held_off;
    phase_left = 0;
    mode = RX_OPEN;
    pat = 8'hff;
    held_off = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && n_sent >= HOLD_AT_REQ) begin
        held_off = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (phase_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 120);
        pat = 8'($urandom) | 8'h01;
      end
      case (mode)
        RX_OPEN: m_tready <= 1'b1;
        RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
        default: begin
          m_tready <= pat[0];
          pat = {pat[0], pat[7:1]};
        end
      endcase
      phase_left--;
      @(posedge clk);
    end
  end

  initial begin : sender
    result_t fixed_res;
    logic [idq_pkg::FUNC_W-1:0] fn;
    logic [idq_pkg::POS_W-1:0] pos;
    int r;
    int push_pct;
    int pop_pct;
    int mode_left;

    directed_rows = '{
      '{idq_pkg::FN_POP_BACK,   32'h0000_0000, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_EMPTY},
      '{idq_pkg::FN_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_EMPTY},
      '{idq_pkg::FN_READ,       32'h0000_0000, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_RANGE},
      '{idq_pkg::FN_WRITE,      32'hffff_ffff, 4'd15, 5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_RANGE},
      '{FN_SPARE_6,             32'h1234_5678, 4'd3,  5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{FN_SPARE_7,             32'hffff_ffff, 4'd15, 5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_PUSH_BACK,  32'h7fff_ffff, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd1,  idq_pkg::ST_OK},
      '{idq_pkg::FN_PUSH_FRONT, 32'h8000_0000, 4'd15, 5'd1,
        1'b1, 32'h0000_0000, 5'd2,  idq_pkg::ST_OK},
      '{idq_pkg::FN_READ,       32'h0000_0000, 4'd0,  5'd1,
        1'b1, 32'h8000_0000, 5'd2,  idq_pkg::ST_OK},
      '{idq_pkg::FN_READ,       32'h0000_0000, 4'd1,  5'd1,
        1'b1, 32'h7fff_ffff, 5'd2,  idq_pkg::ST_OK},
      '{idq_pkg::FN_READ,       32'h0000_0000, 4'd2,  5'd1,
        1'b1, 32'h0000_0000, 5'd2,  idq_pkg::ST_RANGE},
      '{idq_pkg::FN_WRITE,      32'h0000_0000, 4'd1,  5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_POP_BACK,   32'h0000_0000, 4'd0,  5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_PUSH_FRONT, 32'h5a5a_5a5a, 4'd0,  5'd16,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_PUSH_BACK,  32'hffff_ffff, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd16, idq_pkg::ST_FULL},
      '{idq_pkg::FN_PUSH_FRONT, 32'h0000_0000, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd16, idq_pkg::ST_FULL},
      '{idq_pkg::FN_READ,       32'h0000_0000, 4'd15, 5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_WRITE,      32'hffff_ffff, 4'd15, 5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_WRITE,      32'h0000_0001, 4'd0,  5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_READ,       32'h0000_0000, 4'd15, 5'd1,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_POP_FRONT,  32'h0000_0000, 4'd0,  5'd16,
        1'b0, 32'h0000_0000, 5'd0,  idq_pkg::ST_OK},
      '{idq_pkg::FN_POP_FRONT,  32'h0000_0000, 4'd0,  5'd1,
        1'b1, 32'h0000_0000, 5'd0,  idq_pkg::ST_EMPTY}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      fixed_res.data = directed_rows[i].exp_data;
      fixed_res.count = directed_rows[i].exp_count;
      fixed_res.status = idq_pkg::status_t'(directed_rows[i].exp_status);
      repeat (directed_rows[i].reps)
        send_request(directed_rows[i].fn, directed_rows[i].value, directed_rows[i].pos,
                     directed_rows[i].fixed_exp, fixed_res);
    end

    fixed_res = '0;
    mode_left = 0;
    push_pct = 40;
    pop_pct = 30;
    repeat (NUM_RANDOM) begin
      // drift between filling, draining and indexed traffic
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: begin push_pct = 65; pop_pct = 15; end
          1: begin push_pct = 15; pop_pct = 65; end
          default: begin push_pct = 30; pop_pct = 25; end
        endcase
      end
      mode_left--;
      r = $urandom_range(0, 99);
      if (r < 3)
        fn = $urandom_range(0, 1) ? FN_SPARE_7 : FN_SPARE_6;
      else if (r < 3 + push_pct)
        fn = $urandom_range(0, 1) ? idq_pkg::FN_PUSH_FRONT : idq_pkg::FN_PUSH_BACK;
      else if (r < 3 + push_pct + pop_pct)
        fn = $urandom_range(0, 1) ? idq_pkg::FN_POP_FRONT : idq_pkg::FN_POP_BACK;
      else
        fn = $urandom_range(0, 1) ? idq_pkg::FN_WRITE : idq_pkg::FN_READ;
      if (shadow_count != '0 && $urandom_range(0, 4) != 0)
        pos = idq_pkg::POS_W'($urandom_range(0, int'(shadow_count) - 1));
      else
        pos = idq_pkg::POS_W'($urandom_range(0, 15));
      send_request(fn, pick_value(), pos, 1'b0, fixed_res);
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/idq_pkg.sv
sv/idq_ram.sv
sv/idq_ctrl.sv
sv/indexed_double_ended_queue_top.sv
bench/tb.sv
